// ===== src/tcet_pkg.sv =====
`timescale 1ns / 1ps

package tcet_pkg;

    localparam int unsigned PTS_PER_FRAME_DEF = 5;
    localparam int unsigned ID_COUNT          = 16;
    localparam int unsigned ID_W              = 4;
    localparam int unsigned CRD_W             = 16;
    localparam int unsigned SCR_W             = 12;
    localparam int unsigned COV_W             = 5;

    localparam logic [SCR_W-1:0] SCREEN_W_RST = 12'd1024;
    localparam logic [SCR_W-1:0] SCREEN_H_RST = 12'd600;

    // register indexes, decoded from paddr[2]
    localparam logic REG_SCREEN_W = 1'b0;
    localparam logic REG_SCREEN_H = 1'b1;

    typedef enum logic {
        CMD_HEADER = 1'b0,
        CMD_POINT  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_UP    = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RGN_NONE     = 3'd0,
        RGN_TOP_L    = 3'd1,
        RGN_TOP_R    = 3'd2,
        RGN_CENTER   = 3'd3,
        RGN_BOT_L    = 3'd4,
        RGN_BOT_R    = 3'd5
    } t_region;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_PRD,
        S_PEV,
        S_UP,
        S_UEV
    } t_state;

    typedef struct packed {
        logic [SCR_W-1:0] height;
        logic [SCR_W-1:0] width;
    } t_screen_cfg;

    // one buffered point of a frame
    typedef struct packed {
        logic [CRD_W-1:0] size;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] x;
        logic [ID_W-1:0]  id;
    } t_point;

endpackage

// ===== src/tcet_ram.sv =====
`timescale 1ns / 1ps

module tcet_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tcet_apb.sv =====
`timescale 1ns / 1ps

module tcet_apb
    import tcet_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_screen_cfg o_cfg
);

    logic [SCR_W-1:0] r_width;
    logic [SCR_W-1:0] r_height;
    logic             wr;

    // word aligned: byte address bits 1:0 are ignored
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SCREEN_W_RST;
            r_height <= SCREEN_H_RST;
        end else if (wr) begin
            if (paddr[2] == REG_SCREEN_W) begin
                r_width <= pwdata[SCR_W-1:0];
            end else begin
                r_height <= pwdata[SCR_W-1:0];
            end
        end
    end

    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_SCREEN_H) ? 32'(r_height) : 32'(r_width);
    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;

endmodule

// ===== src/tcet_region.sv =====
`timescale 1ns / 1ps

module tcet_region
    import tcet_pkg::*;
(
    input  logic             i_clk,
    input  t_screen_cfg      i_cfg,
    input  logic [CRD_W-1:0] i_x,
    input  logic [CRD_W-1:0] i_y,
    output t_region          o_region
);

    // v / 5 by reciprocal, exact for every 14-bit v
    function automatic logic [SCR_W-1:0] div5(input logic [13:0] v);
        logic [29:0] p;
        p = 30'(v) * 30'd52429;
        return p[29:18];
    endfunction

    logic [SCR_W-1:0] r_w1, r_w2, r_w3, r_w4;
    logic [SCR_W-1:0] r_h1, r_h2, r_h3, r_h4;

    always_ff @(posedge i_clk) begin
        r_w1 <= div5(14'(i_cfg.width));
        r_w2 <= div5({1'b0, i_cfg.width, 1'b0});
        r_w3 <= div5(14'(i_cfg.width) + {1'b0, i_cfg.width, 1'b0});
        r_w4 <= div5({i_cfg.width, 2'b00});
        r_h1 <= div5(14'(i_cfg.height));
        r_h2 <= div5({1'b0, i_cfg.height, 1'b0});
        r_h3 <= div5(14'(i_cfg.height) + {1'b0, i_cfg.height, 1'b0});
        r_h4 <= div5({i_cfg.height, 2'b00});
    end

    logic left, right, top, bottom, cx, cy;

    always_comb begin
        left   = i_x <  CRD_W'(r_w1);
        right  = i_x >= CRD_W'(r_w4);
        top    = i_y <  CRD_W'(r_h1);
        bottom = i_y >= CRD_W'(r_h4);
        cx     = (i_x >= CRD_W'(r_w2)) && (i_x < CRD_W'(r_w3));
        cy     = (i_y >= CRD_W'(r_h2)) && (i_y < CRD_W'(r_h3));
        priority if (left && top) begin
            o_region = RGN_TOP_L;
        end else if (right && top) begin
            o_region = RGN_TOP_R;
        end else if (cx && cy) begin
            o_region = RGN_CENTER;
        end else if (left && bottom) begin
            o_region = RGN_BOT_L;
        end else if (right && bottom) begin
            o_region = RGN_BOT_R;
        end else begin
            o_region = RGN_NONE;
        end
    end

endmodule

// ===== src/touch_contact_event_tracker_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser command, tdata count/id/x/y/size
// m_axis    out  m_axis_tvalid/m_axis_tready    tuser event kind, tdata event, tlast
// apb       in   psel/penable/pwrite, pready=1  screen_width @0x0, screen_height @0x4
//
// Headers and non-final points are taken in S_IDLE. The final point of a frame
// (or an empty header) starts the event sequencer: per DOWN/MOVE one frame-buffer
// RAM read (S_PRD, then S_PEV), per UP one last-position RAM read (S_UP, then
// S_UEV), plus one release scan in S_UP when no id is released. An oversized
// header or a duplicate id goes to S_ERR, which emits one ERROR event.
// Sync active-low reset clears the tracking and frame control state; both RAMs
// hold no reset value and are only read after a write. Input is taken only while
// the sequencer is idle; an output stall holds the sequencer and the event
// already registered at the output.

module touch_contact_event_tracker_unit
    import tcet_pkg::*;
#(
    parameter int unsigned PTS_PER_FRAME = PTS_PER_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] point_count, [7:4] track_id, [23:8] pos_x, [39:24] pos_y,
    // [55:40] contact_size
    input  logic [55:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] event_id, [19:4] event_x, [35:20] event_y, [51:36] event_size,
    // [54:52] region_code, [59:55] coverage_mask, [63:60] zero
    output logic [63:0] m_axis_tdata,
    // [1:0] event_kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CNT_W = $clog2(PTS_PER_FRAME + 1);
    localparam int unsigned FP_AW = (PTS_PER_FRAME > 1) ? $clog2(PTS_PER_FRAME) : 1;
    localparam int unsigned FP_W  = $bits(t_point);
    localparam int unsigned LP_W  = 2 * CRD_W;

    t_screen_cfg cfg;
    t_region     region;

    tcet_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // frame point buffer
    logic             fp_we, fp_re;
    logic [FP_AW-1:0] fp_waddr, fp_raddr;
    t_point           fp_wdata, fp_rd;
    logic [FP_W-1:0]  fp_rdata;

    tcet_ram #(.WIDTH(FP_W), .DEPTH(PTS_PER_FRAME)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fp_we),
        .i_waddr (fp_waddr),
        .i_wdata (fp_wdata),
        .i_re    (fp_re),
        .i_raddr (fp_raddr),
        .o_rdata (fp_rdata)
    );
    assign fp_rd = t_point'(fp_rdata);

    // last position per track id, {y, x}
    logic            lp_we, lp_re;
    logic [ID_W-1:0] lp_waddr, lp_raddr;
    logic [LP_W-1:0] lp_wdata, lp_rdata;

    tcet_ram #(.WIDTH(LP_W), .DEPTH(ID_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (lp_we),
        .i_waddr (lp_waddr),
        .i_wdata (lp_wdata),
        .i_re    (lp_re),
        .i_raddr (lp_raddr),
        .o_rdata (lp_rdata)
    );

    tcet_region u_region (
        .i_clk    (i_clk),
        .i_cfg    (cfg),
        .i_x      (fp_rd.x),
        .i_y      (fp_rd.y),
        .o_region (region)
    );

    // input fields
    logic [3:0]       in_count;
    logic [ID_W-1:0]  in_id;
    t_cmd             in_cmd;
    assign in_count = s_axis_tdata[3:0];
    assign in_id    = s_axis_tdata[7:4];
    assign in_cmd   = t_cmd'(s_axis_tuser);

    // state
    t_state               r_state, n_state;
    logic [ID_COUNT-1:0]  r_active, n_active;
    logic [ID_COUNT-1:0]  r_seen, n_seen;
    logic [CNT_W-1:0]     r_exp, n_exp;
    logic [CNT_W-1:0]     r_rcv, n_rcv;
    logic                 r_dup, n_dup;
    logic [COV_W-1:0]     r_cov, n_cov;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [ID_COUNT-1:0]  r_cur, n_cur;
    logic [ID_COUNT-1:0]  r_rel, n_rel;
    logic [ID_W-1:0]      r_up_id, n_up_id;

    // output register
    logic             r_out_vld, n_out_vld;
    t_kind            r_o_kind, n_o_kind;
    logic [ID_W-1:0]  r_o_id, n_o_id;
    logic [CRD_W-1:0] r_o_x, n_o_x;
    logic [CRD_W-1:0] r_o_y, n_o_y;
    logic [CRD_W-1:0] r_o_size, n_o_size;
    t_region          r_o_rgn, n_o_rgn;
    logic [COV_W-1:0] r_o_cov, n_o_cov;
    logic             r_o_last, n_o_last;

    logic                in_acc, slot_free, load;
    logic [ID_COUNT-1:0] pt_bit, fp_bit, up_bit, after_cur;
    logic [ID_W-1:0]     rel_low;
    logic [COV_W-1:0]    rgn_bit;
    logic                final_pt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_vld || m_axis_tready;

    // lowest pending release
    always_comb begin
        rel_low = '0;
        for (int i = ID_COUNT - 1; i >= 0; i--) begin
            if (r_rel[i]) begin
                rel_low = ID_W'(i);
            end
        end
    end

    always_comb begin
        unique case (region)
            RGN_TOP_L:  rgn_bit = 5'b00001;
            RGN_TOP_R:  rgn_bit = 5'b00010;
            RGN_CENTER: rgn_bit = 5'b00100;
            RGN_BOT_L:  rgn_bit = 5'b01000;
            RGN_BOT_R:  rgn_bit = 5'b10000;
            default:    rgn_bit = 5'b00000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_seen    <= '0;
            r_exp     <= '0;
            r_rcv     <= '0;
            r_dup     <= 1'b0;
            r_cov     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_seen    <= n_seen;
            r_exp     <= n_exp;
            r_rcv     <= n_rcv;
            r_dup     <= n_dup;
            r_cov     <= n_cov;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_rel    <= n_rel;
        r_up_id  <= n_up_id;
        r_o_kind <= n_o_kind;
        r_o_id   <= n_o_id;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_o_size <= n_o_size;
        r_o_rgn  <= n_o_rgn;
        r_o_cov  <= n_o_cov;
        r_o_last <= n_o_last;
    end

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_seen   = r_seen;
        n_exp    = r_exp;
        n_rcv    = r_rcv;
        n_dup    = r_dup;
        n_cov    = r_cov;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_cur    = r_cur;
        n_rel    = r_rel;
        n_up_id  = r_up_id;

        load     = 1'b0;
        n_o_kind = r_o_kind;
        n_o_id   = r_o_id;
        n_o_x    = r_o_x;
        n_o_y    = r_o_y;
        n_o_size = r_o_size;
        n_o_rgn  = r_o_rgn;
        n_o_cov  = r_o_cov;
        n_o_last = r_o_last;

        fp_we    = 1'b0;
        fp_waddr = r_rcv[FP_AW-1:0];
        fp_wdata = '{size: s_axis_tdata[55:40], y: s_axis_tdata[39:24],
                     x: s_axis_tdata[23:8], id: in_id};
        fp_re    = 1'b0;
        fp_raddr = r_idx[FP_AW-1:0];
        lp_we    = 1'b0;
        lp_waddr = fp_rd.id;
        lp_wdata = {fp_rd.y, fp_rd.x};
        lp_re    = 1'b0;
        lp_raddr = rel_low;

        pt_bit    = ID_COUNT'(1) << in_id;
        fp_bit    = ID_COUNT'(1) << fp_rd.id;
        up_bit    = ID_COUNT'(1) << r_up_id;
        after_cur = r_cur | fp_bit;
        final_pt  = (CNT_W'(r_idx + 1'b1) == r_cnt);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == CMD_HEADER) begin
                        n_seen = '0;
                        n_exp  = '0;
                        n_rcv  = '0;
                        n_dup  = 1'b0;
                        if (5'(in_count) > 5'(PTS_PER_FRAME)) begin
                            n_state = S_ERR;
                        end else if (in_count == 4'd0) begin
                            // empty frame releases every active id
                            n_rel    = r_active;
                            n_active = '0;
                            n_state  = S_UP;
                        end else begin
                            n_exp = CNT_W'(in_count);
                        end
                    end else if (r_exp != '0 && 32'(r_rcv) < PTS_PER_FRAME) begin
                        fp_we  = 1'b1;
                        n_seen = r_seen | pt_bit;
                        n_dup  = r_dup | ((r_seen & pt_bit) != '0);
                        n_rcv  = CNT_W'(r_rcv + 1'b1);
                        if (CNT_W'(r_rcv + 1'b1) >= r_exp) begin
                            n_seen = '0;
                            n_exp  = '0;
                            n_rcv  = '0;
                            n_dup  = 1'b0;
                            if (r_dup || ((r_seen & pt_bit) != '0)) begin
                                n_state = S_ERR;
                            end else begin
                                n_cnt   = r_exp;
                                n_idx   = '0;
                                n_cur   = '0;
                                n_state = S_PRD;
                            end
                        end
                    end
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    load     = 1'b1;
                    n_o_kind = KIND_ERROR;
                    n_o_id   = '0;
                    n_o_x    = '0;
                    n_o_y    = '0;
                    n_o_size = '0;
                    n_o_rgn  = RGN_NONE;
                    n_o_cov  = r_cov;
                    n_o_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PRD: begin
                fp_re   = 1'b1;
                n_state = S_PEV;
            end
            S_PEV: begin
                if (slot_free) begin
                    load     = 1'b1;
                    lp_we    = 1'b1;
                    n_cov    = r_cov | rgn_bit;
                    n_o_kind = ((r_active & fp_bit) != '0) ? KIND_MOVE : KIND_DOWN;
                    n_o_id   = fp_rd.id;
                    n_o_x    = fp_rd.x;
                    n_o_y    = fp_rd.y;
                    n_o_size = fp_rd.size;
                    n_o_rgn  = region;
                    n_o_cov  = r_cov | rgn_bit;
                    n_o_last = final_pt && ((r_active & ~after_cur) == '0);
                    n_cur    = after_cur;
                    if (final_pt) begin
                        n_rel    = r_active & ~after_cur;
                        n_active = after_cur;
                        n_state  = S_UP;
                    end else begin
                        n_idx   = CNT_W'(r_idx + 1'b1);
                        n_state = S_PRD;
                    end
                end
            end
            S_UP: begin
                if (r_rel == '0) begin
                    n_state = S_IDLE;
                end else begin
                    lp_re   = 1'b1;
                    n_up_id = rel_low;
                    n_state = S_UEV;
                end
            end
            S_UEV: begin
                if (slot_free) begin
                    load     = 1'b1;
                    n_o_kind = KIND_UP;
                    n_o_id   = r_up_id;
                    n_o_x    = lp_rdata[CRD_W-1:0];
                    n_o_y    = lp_rdata[LP_W-1:CRD_W];
                    n_o_size = '0;
                    n_o_rgn  = RGN_NONE;
                    n_o_cov  = r_cov;
                    n_o_last = ((r_rel & ~up_bit) == '0);
                    n_rel    = r_rel & ~up_bit;
                    n_state  = ((r_rel & ~up_bit) == '0) ? S_IDLE : S_UP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_vld = load || (r_out_vld && !m_axis_tready);
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {4'b0000, r_o_cov, r_o_rgn, r_o_size, r_o_y, r_o_x, r_o_id};

endmodule

// ===== src/tcet_checker.sv =====
`timescale 1ns / 1ps

module tcet_checker
    import tcet_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        pready
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // a result of kind ERROR is last and carries no id, position, size or region
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
            m_axis_tlast && m_axis_tdata[54:0] == '0)
        else $error("malformed error result");

    // releases carry no size and no region
    a_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_UP |-> m_axis_tdata[54:36] == '0)
        else $error("up event with size or region");

    a_rgn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[54:52] <= 3'd5)
        else $error("region code out of range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind touch_contact_event_tracker_unit tcet_checker u_tcet_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

// ===== dv/touch_contact_event_tracker_unit_test.sv =====
`timescale 1ns / 1ps

// One emitted touch event, as seen on the master stream.
typedef struct {
    tcet_pkg::t_kind   kind;
    logic [3:0]        id;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [15:0]       size;
    tcet_pkg::t_region region;
    logic [4:0]        cov;
    logic              last;
} t_touch_event;

// Contact tracker predictor plus in-order event checker.
class contact_event_scoreboard;
    logic [11:0]       screen_w;
    logic [11:0]       screen_h;
    logic [15:0]       live_ids;
    logic [31:0]       last_pos [16];
    tcet_pkg::t_point  frame_buf [tcet_pkg::PTS_PER_FRAME_DEF];
    logic [15:0]       ids_seen;
    int unsigned       want_pts;
    int unsigned       got_pts;
    bit                dup_seen;
    logic [4:0]        coverage;
    t_touch_event      pending_events [$];
    int                failures;

    function new();
        screen_w   = tcet_pkg::SCREEN_W_RST;
        screen_h   = tcet_pkg::SCREEN_H_RST;
        live_ids   = '0;
        coverage   = '0;
        failures   = 0;
        drop_frame();
    endfunction

    function void set_screen(logic reg_sel, logic [11:0] value);
        if (reg_sel == tcet_pkg::REG_SCREEN_W) begin
            screen_w = value;
        end else begin
            screen_h = value;
        end
    endfunction

    function void drop_frame();
        ids_seen = '0;
        want_pts = 0;
        got_pts  = 0;
        dup_seen = 1'b0;
    endfunction

    // first match wins: TL, TR, center, BL, BR
    function tcet_pkg::t_region region_of(logic [15:0] x, logic [15:0] y);
        int unsigned w;
        int unsigned h;
        bit left, right, top, bottom, cx, cy;
        w      = screen_w;
        h      = screen_h;
        left   = x < w / 5;
        right  = x >= w * 4 / 5;
        top    = y < h / 5;
        bottom = y >= h * 4 / 5;
        cx     = x >= w * 2 / 5 && x < w * 3 / 5;
        cy     = y >= h * 2 / 5 && y < h * 3 / 5;
        if (left && top) return tcet_pkg::RGN_TOP_L;
        if (right && top) return tcet_pkg::RGN_TOP_R;
        if (cx && cy) return tcet_pkg::RGN_CENTER;
        if (left && bottom) return tcet_pkg::RGN_BOT_L;
        if (right && bottom) return tcet_pkg::RGN_BOT_R;
        return tcet_pkg::RGN_NONE;
    endfunction

    function void push_event(tcet_pkg::t_kind kind, logic [3:0] id, logic [15:0] x,
                             logic [15:0] y, logic [15:0] size,
                             tcet_pkg::t_region region, logic last);
        t_touch_event ev;
        ev.kind   = kind;
        ev.id     = id;
        ev.x      = x;
        ev.y      = y;
        ev.size   = size;
        ev.region = region;
        ev.cov    = coverage;
        ev.last   = last;
        pending_events.push_back(ev);
    endfunction

    // DOWN/MOVE per buffered point, then UP per released id, ascending
    function void close_frame(int unsigned count);
        logic [15:0]       cur;
        logic [15:0]       released;
        int unsigned       total;
        int unsigned       k;
        tcet_pkg::t_point  p;
        tcet_pkg::t_region rg;
        tcet_pkg::t_kind   kd;
        cur = '0;
        for (int i = 0; i < count; i++) cur[frame_buf[i].id] = 1'b1;
        released = live_ids & ~cur;
        total    = count + $countones(released);
        k        = 0;
        for (int i = 0; i < count; i++) begin
            p  = frame_buf[i];
            kd = live_ids[p.id] ? tcet_pkg::KIND_MOVE : tcet_pkg::KIND_DOWN;
            rg = region_of(p.x, p.y);
            last_pos[p.id] = {p.y, p.x};
            if (rg != tcet_pkg::RGN_NONE) coverage[rg - 1] = 1'b1;
            k++;
            push_event(kd, p.id, p.x, p.y, p.size, rg, k == total);
        end
        for (int i = 0; i < 16; i++) begin
            if (released[i]) begin
                k++;
                push_event(tcet_pkg::KIND_UP, 4'(i), last_pos[i][15:0], last_pos[i][31:16],
                           16'd0, tcet_pkg::RGN_NONE, k == total);
            end
        end
        live_ids = cur;
    endfunction

    function void note_request(logic cmd, logic [3:0] count, logic [3:0] id,
                               logic [15:0] x, logic [15:0] y, logic [15:0] size);
        int unsigned n;
        bit          dup;
        if (cmd == tcet_pkg::CMD_HEADER) begin
            drop_frame();
            if (count > tcet_pkg::PTS_PER_FRAME_DEF) begin
                push_event(tcet_pkg::KIND_ERROR, 4'd0, 16'd0, 16'd0, 16'd0,
                           tcet_pkg::RGN_NONE, 1'b1);
            end else if (count == 0) begin
                close_frame(0);
            end else begin
                want_pts = count;
            end
        end else if (want_pts != 0 && got_pts < tcet_pkg::PTS_PER_FRAME_DEF) begin
            frame_buf[got_pts] = {size, y, x, id};
            if (ids_seen[id]) dup_seen = 1'b1;
            ids_seen[id] = 1'b1;
            got_pts++;
            if (got_pts >= want_pts) begin
                n   = want_pts;
                dup = dup_seen;
                drop_frame();
                if (dup) begin
                    push_event(tcet_pkg::KIND_ERROR, 4'd0, 16'd0, 16'd0, 16'd0,
                               tcet_pkg::RGN_NONE, 1'b1);
                end else begin
                    close_frame(n);
                end
            end
        end
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    function void check_event(t_touch_event seen);
        t_touch_event want;
        if (pending_events.size() == 0) begin
            failures++;
            $display("%0t: event with none expected, expected nothing, actual kind %0d id %0d",
                     $time, seen.kind, seen.id);
            return;
        end
        want = pending_events.pop_front();
        compare_field("event_kind", want.kind, seen.kind);
        compare_field("event_id", want.id, seen.id);
        compare_field("event_x", want.x, seen.x);
        compare_field("event_y", want.y, seen.y);
        compare_field("event_size", want.size, seen.size);
        compare_field("region_code", want.region, seen.region);
        compare_field("coverage_mask", want.cov, seen.cov);
        compare_field("last_event", want.last, seen.last);
    endfunction
endclass

module touch_contact_event_tracker_unit_test;
    import tcet_pkg::*;

    // settle time after the last expected event: long enough for the sequencer
    // to return to idle, so this also catches stray events
    localparam int SETTLE_CYCLES = 60;
    // budget for ~110 requests and their events under output stalls, plus config drains
    localparam int CYCLE_LIMIT   = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [3:0] point_count, [7:4] track_id, [23:8] pos_x, [39:24] pos_y,
    // [55:40] contact_size
    logic [55:0] s_axis_tdata;
    // [0] command
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] event_id, [19:4] event_x, [35:20] event_y, [51:36] event_size,
    // [54:52] region_code, [59:55] coverage_mask
    logic [63:0] m_axis_tdata;
    // [1:0] event_kind
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    touch_contact_event_tracker_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    contact_event_scoreboard tracker_sb;
    bit                      idling = 1'b1;  // random gaps on both streams
    int unsigned             stall_left = 0;
    int unsigned             cycle_count = 0;
    t_touch_event            seen_event;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Event sink: check every accepted event, then decide next-cycle tready.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_event.kind   = t_kind'(m_axis_tuser);
            seen_event.id     = m_axis_tdata[3:0];
            seen_event.x      = m_axis_tdata[19:4];
            seen_event.y      = m_axis_tdata[35:20];
            seen_event.size   = m_axis_tdata[51:36];
            seen_event.region = t_region'(m_axis_tdata[54:52]);
            seen_event.cov    = m_axis_tdata[59:55];
            seen_event.last   = m_axis_tlast;
            tracker_sb.check_event(seen_event);
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("touch_contact_event_tracker_unit test failed");
            $finish;
        end
    end

    // Push one request into the slave stream; tvalid stays up afterwards so
    // back-to-back requests need no re-arm. An optional gap with tvalid low comes first.
    task automatic send_request(input logic cmd, input logic [3:0] count,
                                input logic [3:0] id, input logic [15:0] x,
                                input logic [15:0] y, input logic [15:0] size);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {size, y, x, id, count};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker_sb.note_request(cmd, count, id, x, y, size);
    endtask

    // header: point fields carry random junk, the block must ignore them
    task automatic send_header(input logic [3:0] count);
        send_request(CMD_HEADER, count, 4'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
    endtask

    task automatic send_point(input logic [3:0] id, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] size);
        send_request(CMD_POINT, 4'($urandom), id, x, y, size);
    endtask

    // Drop tvalid, let every expected event drain, then allow the sequencer
    // time to finish anything that produces no event.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker_sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write then read-back of one screen register, only with the block idle
    task automatic write_screen(input logic reg_sel, input logic [11:0] value);
        logic [31:0] readback;
        wait_for_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {20'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker_sb.set_screen(reg_sel, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {20'd0, value}) begin
            tracker_sb.failures++;
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, reg_sel, {20'd0, value}, readback);
        end
    endtask

    task automatic set_screen_size(input logic [11:0] w, input logic [11:0] h);
        write_screen(REG_SCREEN_W, w);
        write_screen(REG_SCREEN_H, h);
    endtask

    // mix of full-range, edge and on-screen coordinates (around the bounds)
    function automatic logic [15:0] random_coord(input logic [11:0] dim);
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom_range(0, dim + 2));
        endcase
    endfunction

    // ids mostly from a small pool so MOVE and UP events are common
    function automatic logic [3:0] random_id();
        if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, 6));
    endfunction

    // Mostly well-formed frames with random content; the rest is noise:
    // stray points, oversized counts, empty frames, duplicate ids and
    // frames cut short by the next header.
    task automatic run_frames(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned pts;
        int unsigned kept;
        logic [15:0] used;
        logic [3:0]  id;
        logic [3:0]  prev_id;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                // stray point when idle; joins a frame if one was cut short
                send_point(4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (pick == 1) begin
                send_header(4'($urandom_range(PTS_PER_FRAME_DEF + 1, 15)));
                sent++;
            end else if (pick == 2) begin
                send_header(4'd0);
                sent++;
            end else begin
                pts  = $urandom_range(1, PTS_PER_FRAME_DEF);
                kept = (pick == 3) ? $urandom_range(0, pts - 1) : pts;
                send_header(4'(pts));
                sent++;
                used    = '0;
                prev_id = '0;
                for (int k = 0; k < kept; k++) begin
                    if (k > 0 && $urandom_range(0, 11) == 0) begin
                        id = prev_id;  // duplicate id
                    end else begin
                        do id = random_id(); while (used[id]);
                    end
                    used[id] = 1'b1;
                    prev_id  = id;
                    send_point(id, random_coord(tracker_sb.screen_w),
                               random_coord(tracker_sb.screen_h), 16'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        tracker_sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset screen size (1024 x 600)
        set_screen_size(12'd1024, 12'd600);
        send_header(4'd0);                                  // empty, nothing active
        send_point(4'd15, 16'hffff, 16'hffff, 16'hffff);    // stray point
        send_header(4'd1);
        send_point(4'd0, 16'd0, 16'd0, 16'd0);              // DOWN, top-left
        send_header(4'd2);
        send_point(4'd0, 16'd1023, 16'd0, 16'h1234);        // MOVE, top-right
        send_point(4'd15, 16'd512, 16'd300, 16'hffff);      // DOWN, center
        send_header(4'd5);                                  // full frame, id 0 goes up
        send_point(4'd3, 16'd0, 16'd599, 16'd1);            // bottom-left
        send_point(4'd7, 16'd1023, 16'd599, 16'd2);         // bottom-right
        send_point(4'd9, 16'hffff, 16'hffff, 16'h8000);
        send_point(4'd12, 16'd100, 16'd300, 16'h00ff);      // no region
        send_point(4'd15, 16'd410, 16'd240, 16'h7fff);      // center low corner
        send_header(4'd6);                                  // count too large
        send_header(4'd15);
        send_header(4'd2);                                  // duplicate id
        send_point(4'd4, 16'd10, 16'd10, 16'd5);
        send_point(4'd4, 16'd20, 16'd20, 16'd6);
        send_header(4'd3);                                  // abandoned by next header
        send_point(4'd1, 16'd30, 16'd30, 16'd7);
        send_header(4'd1);
        send_point(4'd2, 16'd900, 16'd500, 16'd8);          // releases all others
        send_header(4'd0);                                  // empty, releases id 2

        // random phases over a spread of screen sizes, extremes included
        run_frames(15);
        set_screen_size(12'd4095, 12'd4095);
        run_frames(15);
        set_screen_size(12'd5, 12'd5);
        idling = 1'b0;                                      // a stretch at full rate
        run_frames(15);
        set_screen_size(12'd0, 12'd3);                      // degenerate bounds
        idling = 1'b1;
        run_frames(12);
        set_screen_size(12'd4095, 12'd5);
        run_frames(12);
        set_screen_size(12'd800, 12'd480);
        idling = 1'b0;                                      // closing part, no gaps
        run_frames(16);

        wait_for_idle();
        if (tracker_sb.failures == 0) begin
            $display("touch_contact_event_tracker_unit test passed");
        end else begin
            $display("touch_contact_event_tracker_unit test failed");
        end
        $finish;
    end

endmodule
